// ===== hdl/keyword_integer_scanner_unit_macros.svh =====
// Assertion macros shared by the keyword integer scanner RTL.
`ifndef KEYWORD_INTEGER_SCANNER_UNIT_MACROS_SVH
`define KEYWORD_INTEGER_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication.
`define KIS_ASSERT_IMPL(label, clk, rst, prop_a, prop_c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop_a) |-> (prop_c)) \
      else $error(msg);

// Next-cycle implication.
`define KIS_ASSERT_NEXT(label, clk, rst, prop_a, prop_c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop_a) |=> (prop_c)) \
      else $error(msg);

`endif

// ===== hdl/kis_pkg.sv =====
// Types and constants of the keyword integer scanner.
`timescale 1ns / 1ps

package kis_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int KW_LEN_W    = 4;
   localparam int VALUE_W     = 32;
   localparam int STOP_W      = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_KEYWORD_CHARS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEYWORD_LENGTH = 2'd1;

   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_VT       = 8'h0B;
   localparam logic [7:0] CH_FORMFEED = 8'h0C;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_HASH     = 8'h23;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_COLON    = 8'h3A;

   localparam logic [VALUE_W-1:0] MAG_CAP   = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_LEAD   = 3'd1,
      PH_SIGN   = 3'd2,
      PH_DIGIT  = 3'd3,
      PH_TAIL   = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] value;
      logic [STOP_W-1:0]         stop_position;
   } rsp_item_type;

endpackage

// ===== hdl/keyword_integer_scanner_unit.sv =====
// Keyword integer scanner: finds a keyword in a byte stream and converts the decimal after it.
//
// Usage:
//   csr_*  : write keyword_chars (index 0, first char in low byte) and keyword_length
//            (index 1) while the block is idle; index 2 and 3 are ignored.
//   req_*  : one stream byte per item, last_byte marks the end of a stream.
//   rsp_*  : at most one item per stream: found, value and stop_position.
// Timing:
//   A byte is held in the input register and is processed as it moves on; its result is
//   then held in the result register, which drives rsp_valid.
//   One byte per cycle unless stalled: the keyword window compare, comment tracking and
//   the decimal accumulate (shift-add times ten with saturation) are all combinational.
// Stall:
//   The input register advances only while the result register is empty or being
//   taken, so a stall on rsp_stall backs up into req_stall after one buffered byte.
// Reset:
//   Synchronous reset clears the scan state, keyword_chars to 0 and keyword_length
//   to 1. After each last byte the scan state returns to that point, registers kept.
`timescale 1ns / 1ps
`include "keyword_integer_scanner_unit_macros.svh"

module keyword_integer_scanner_unit
   import kis_pkg::*;
#(
   parameter int KEYWORD_MAX   = 8,
   parameter int POSITION_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_item_type           req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_item_type           rsp_item
);

   localparam int KW_BITS = KEYWORD_MAX * 8;

   // configuration
   logic [CSR_DATA_W-1:0] kw_chars_ff, kw_chars_in;
   logic [KW_LEN_W-1:0]   kw_len_ff, kw_len_in;
   logic [KW_LEN_W-1:0]   kw_len_eff;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;

   // scan state
   logic                     cmt_ff, cmt_in;
   logic                     skip_ff, skip_in;
   logic [KW_BITS-1:0]       win_ff, win_in;
   logic [KEYWORD_MAX-1:0]   elig_ff, elig_in;
   phase_type                phase_ff, phase_in;
   logic                     tok_ff, tok_in;
   logic                     neg_ff, neg_in;
   logic [VALUE_W-1:0]       mag_ff, mag_in;
   logic [POSITION_BITS-1:0] cnt_ff, cnt_in;
   logic                     have_prev_ff, have_prev_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // working signals
   logic                     adv;
   logic [7:0]               cur;
   logic                     last;
   logic                     skip_mid, cmt_mid;
   logic [KEYWORD_MAX-1:0]   elig_a, elig_b;
   logic [KW_BITS-1:0]       win_sh;
   logic                     hit_a, hit_b;
   phase_type                phase_mid, phase_st;
   logic                     tok_mid, neg_mid, tok_st, neg_st;
   logic [VALUE_W-1:0]       mag_mid, mag_st;
   logic                     is_blank, is_digit, is_space_class, term;
   logic [VALUE_W+3:0]       mag_x10;
   logic [POSITION_BITS:0]   pos_next;
   logic                     emit;

   // keyword ending at byte 0 of win, starting at a byte allowed to start one
   function automatic logic kw_hit(input logic [KW_BITS-1:0]     win,
                                   input logic [KEYWORD_MAX-1:0] elig,
                                   input logic [CSR_DATA_W-1:0]  kw,
                                   input logic [KW_LEN_W-1:0]    len);
      logic hit;
      logic all_eq;
      hit = 1'b0;
      for (int n = 1; n <= KEYWORD_MAX; n++) begin
         all_eq = elig[n-1];
         for (int i = 0; i < n; i++) begin
            all_eq = all_eq & (win[(n-1-i)*8 +: 8] == kw[i*8 +: 8]);
         end
         if (len == KW_LEN_W'(n)) begin
            hit = all_eq;
         end
      end
      return hit;
   endfunction

   function automatic logic [VALUE_W-1:0] token_value(input logic               neg,
                                                      input logic [VALUE_W-1:0] mag);
      logic [VALUE_W-1:0] res;
      if (neg) begin
         res = (mag >= MAG_CAP) ? MAG_CAP : (VALUE_W'(0) - mag);
      end else begin
         res = (mag > VALUE_MAX) ? VALUE_MAX : mag;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- configuration
   always_comb begin
      kw_chars_in = kw_chars_ff;
      kw_len_in   = kw_len_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_KEYWORD_CHARS:  kw_chars_in = csr_write_data;
            REG_KEYWORD_LENGTH: kw_len_in   = csr_write_data[KW_LEN_W-1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      if (kw_len_ff == KW_LEN_W'(0)) begin
         kw_len_eff = KW_LEN_W'(1);
      end else if (kw_len_ff > KW_LEN_W'(KEYWORD_MAX)) begin
         kw_len_eff = KW_LEN_W'(KEYWORD_MAX);
      end else begin
         kw_len_eff = kw_len_ff;
      end
   end

   // ---------------------------------------------------------------- handshake
   assign adv       = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !adv;
   assign cur       = in_item_ff.char_in;
   assign last      = in_item_ff.last_byte;

   always_comb begin
      in_item_in  = in_item_ff;
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_item_in  = req_item;
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- comment and keyword
   always_comb begin
      skip_mid = skip_ff;
      cmt_mid  = cmt_ff;
      elig_a   = elig_ff;
      // the previous byte's role is settled now that its successor is here
      if (have_prev_ff) begin
         elig_a[0] = 1'b0;
         if (skip_ff) begin
            skip_mid = 1'b0;
         end else if (win_ff[7:0] == CH_SLASH && cur == CH_STAR) begin
            cmt_mid  = 1'b1;
            skip_mid = 1'b1;
         end else if (cmt_ff) begin
            if (win_ff[7:0] == CH_STAR && cur == CH_SLASH) begin
               cmt_mid  = 1'b0;
               skip_mid = 1'b1;
            end
         end else begin
            elig_a[0] = 1'b1;
         end
      end
      hit_a = kw_hit(win_ff, elig_a, kw_chars_ff, kw_len_eff) && (cur != CH_COLON);

      phase_mid = phase_ff;
      tok_mid   = tok_ff;
      neg_mid   = neg_ff;
      mag_mid   = mag_ff;
      if (phase_ff == PH_SEARCH && hit_a) begin
         phase_mid = PH_LEAD;
         tok_mid   = 1'b0;
         neg_mid   = 1'b0;
         mag_mid   = '0;
      end
   end

   // ---------------------------------------------------------------- token conversion
   assign is_blank       = (cur == CH_SPACE) || (cur == CH_TAB);
   assign is_space_class = is_blank || (cur == CH_LF) || (cur == CH_VT) ||
                           (cur == CH_FORMFEED);
   assign is_digit       = (cur >= CH_ZERO) && (cur <= CH_NINE);
   // digit value is the low nibble for '0'..'9'
   assign mag_x10        = ({4'd0, mag_mid} << 3) + ({4'd0, mag_mid} << 1) +
                           (VALUE_W + 4)'(cur[3:0]);

   always_comb begin
      phase_st = phase_mid;
      tok_st   = tok_mid;
      neg_st   = neg_mid;
      mag_st   = mag_mid;
      term     = 1'b0;
      if (phase_mid == PH_LEAD || phase_mid == PH_SIGN || phase_mid == PH_DIGIT ||
          phase_mid == PH_TAIL) begin
         if (cur == CH_CR || cur == CH_HASH || (is_blank && tok_mid)) begin
            term     = 1'b1;
            phase_st = PH_DONE;
         end else begin
            tok_st = tok_mid | !is_blank;
            case (phase_mid)
               PH_LEAD: begin
                  if (is_space_class) begin
                     phase_st = PH_LEAD;
                  end else if (cur == CH_PLUS) begin
                     phase_st = PH_SIGN;
                  end else if (cur == CH_MINUS) begin
                     neg_st   = 1'b1;
                     phase_st = PH_SIGN;
                  end else if (is_digit) begin
                     mag_st   = VALUE_W'(cur[3:0]);
                     phase_st = PH_DIGIT;
                  end else begin
                     phase_st = PH_TAIL;
                  end
               end
               PH_SIGN: begin
                  if (is_digit) begin
                     mag_st   = VALUE_W'(cur[3:0]);
                     phase_st = PH_DIGIT;
                  end else begin
                     phase_st = PH_TAIL;
                  end
               end
               PH_DIGIT: begin
                  if (is_digit) begin
                     mag_st = (mag_x10 > {4'd0, MAG_CAP}) ? MAG_CAP : mag_x10[VALUE_W-1:0];
                  end else begin
                     phase_st = PH_TAIL;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      win_sh = win_ff;
      for (int j = KEYWORD_MAX - 1; j > 0; j--) begin
         win_sh[j*8 +: 8] = win_ff[(j-1)*8 +: 8];
      end
      win_sh[7:0] = cur;

      // window as seen at the end of a stream: the final byte may start a keyword
      elig_b = elig_a;
      for (int j = KEYWORD_MAX - 1; j > 0; j--) begin
         elig_b[j] = elig_a[j-1];
      end
      elig_b[0] = !skip_mid && !cmt_mid;
      hit_b     = kw_hit(win_sh, elig_b, kw_chars_ff, kw_len_eff);

      cmt_in       = cmt_ff;
      skip_in      = skip_ff;
      win_in       = win_ff;
      elig_in      = elig_ff;
      phase_in     = phase_ff;
      tok_in       = tok_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      have_prev_in = have_prev_ff;
      if (adv) begin
         if (last) begin
            cmt_in       = 1'b0;
            skip_in      = 1'b0;
            win_in       = '0;
            elig_in      = '0;
            phase_in     = PH_SEARCH;
            tok_in       = 1'b0;
            neg_in       = 1'b0;
            mag_in       = '0;
            cnt_in       = '0;
            have_prev_in = 1'b0;
         end else begin
            cmt_in       = cmt_mid;
            skip_in      = skip_mid;
            win_in       = win_sh;
            elig_in      = {elig_b[KEYWORD_MAX-1:1], 1'b0};
            phase_in     = phase_st;
            tok_in       = tok_st;
            neg_in       = neg_st;
            mag_in       = mag_st;
            cnt_in       = cnt_ff + POSITION_BITS'(1);
            have_prev_in = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- result
   assign pos_next = {1'b0, cnt_ff} + (POSITION_BITS + 1)'(1);

   always_comb begin
      emit                      = 1'b0;
      rsp_item_in               = rsp_item_ff;
      rsp_item_in.found         = 1'b1;
      rsp_item_in.value         = token_value(neg_st, mag_st);
      rsp_item_in.stop_position = STOP_W'(cnt_ff);
      if (term) begin
         emit = 1'b1;
      end else if (last) begin
         if (phase_st == PH_SEARCH) begin
            // keyword on the final byte gives an empty token
            emit                      = 1'b1;
            rsp_item_in.found         = hit_b;
            rsp_item_in.value         = '0;
            rsp_item_in.stop_position = hit_b ? STOP_W'(pos_next) : '0;
         end else if (phase_st != PH_DONE) begin
            emit                      = 1'b1;
            rsp_item_in.stop_position = STOP_W'(pos_next);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (adv && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kw_chars_ff  <= '0;
         kw_len_ff    <= KW_LEN_W'(1);
         in_valid_ff  <= 1'b0;
         cmt_ff       <= 1'b0;
         skip_ff      <= 1'b0;
         win_ff       <= '0;
         elig_ff      <= '0;
         phase_ff     <= PH_SEARCH;
         tok_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         cnt_ff       <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kw_chars_ff  <= kw_chars_in;
         kw_len_ff    <= kw_len_in;
         in_valid_ff  <= in_valid_in;
         cmt_ff       <= cmt_in;
         skip_ff      <= skip_in;
         win_ff       <= win_in;
         elig_ff      <= elig_in;
         phase_ff     <= phase_in;
         tok_ff       <= tok_in;
         neg_ff       <= neg_in;
         mag_ff       <= mag_in;
         cnt_ff       <= cnt_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (adv && emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // ---------------------------------------------------------------- checks
   `KIS_ASSERT_NEXT(a_clear_after_last, clock, reset, adv && last,
      phase_ff == PH_SEARCH && cnt_ff == '0 && !have_prev_ff && !cmt_ff,
      "scan state not cleared after last byte")
   `KIS_ASSERT_IMPL(a_search_end_answers, clock, reset, adv && last && phase_ff == PH_SEARCH,
      emit, "stream ended while searching without a result")
   `KIS_ASSERT_IMPL(a_done_silent, clock, reset, adv && !last && phase_ff == PH_DONE,
      !emit, "second result within one stream")
   `KIS_ASSERT_NEXT(a_result_loaded, clock, reset, adv && emit, rsp_valid_ff,
      "result lost on its way to the output register")
   `KIS_ASSERT_IMPL(a_not_found_zero, clock, reset, rsp_valid && !rsp_item.found,
      rsp_item.value == '0 && rsp_item.stop_position == '0,
      "not-found item carries nonzero fields")

endmodule
